[src/lfhc_pkg.sv]
// Package for the fire heat-cell strip: sizes, field widths, cell op codes.
// No dependencies; used by lfhc_cell, lfhc_colour and led_fire_heat_cells.
`default_nettype none

package lfhc_pkg;

  // strip geometry
  localparam int NUM_CELLS = 64;
  localparam int IDX_W     = 6;
  localparam int HEAT_W    = 8;

  // configuration reset values
  localparam logic [7:0] COOLING_RST      = 8'd55;
  localparam logic [7:0] SPARK_CHANCE_RST = 8'd55;

  // configuration register indexes
  localparam logic REG_COOLING      = 1'b0;
  localparam logic REG_SPARK_CHANCE = 1'b1;

  // per-cell operation
  typedef logic [1:0] cell_op_t;
  localparam cell_op_t OP_HOLD    = 2'd0;
  localparam cell_op_t OP_SHIFT   = 2'd1;
  localparam cell_op_t OP_DIFFUSE = 2'd2;

endpackage

`default_nettype wire

[src/lfhc_cell.sv]
// One heat cell of the strip ring: holds a byte, shifts, or diffuses with spark.
// Depends on lfhc_pkg.
`default_nettype none

module lfhc_cell (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire lfhc_pkg::cell_op_t           op,
  input  wire logic [lfhc_pkg::HEAT_W-1:0]  shift_in,
  input  wire logic [lfhc_pkg::HEAT_W-1:0]  below1,
  input  wire logic [lfhc_pkg::HEAT_W-1:0]  below2,
  input  wire logic [lfhc_pkg::HEAT_W-1:0]  spark_add,
  output logic      [lfhc_pkg::HEAT_W-1:0]  heat
);

  // floor(s / 3) for s up to 765 by reciprocal multiply
  function automatic logic [lfhc_pkg::HEAT_W-1:0] div3(input logic [9:0] s);
    logic [20:0] p;
    p = 21'(s) * 21'd683;
    return p[18:11];
  endfunction

  logic [9:0]                   sum;
  logic [lfhc_pkg::HEAT_W-1:0]  heat_next;

  // diffusion sum from the two cells below
  assign sum = 10'(below1) + {1'b0, below2, 1'b0};

  always_comb begin
    case (op)
      lfhc_pkg::OP_HOLD:    heat_next = heat;
      lfhc_pkg::OP_SHIFT:   heat_next = shift_in;
      lfhc_pkg::OP_DIFFUSE: heat_next = div3(sum) + spark_add;
      default:              heat_next = heat;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heat <= '0;
    end else begin
      heat <= heat_next;
    end
  end

endmodule

`default_nettype wire

[src/lfhc_colour.sv]
// Output stage: maps a cell's heat to an HSV colour and holds the result
// transaction until the downstream side takes it. Depends on lfhc_pkg.
`default_nettype none

module lfhc_colour (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load,
  input  wire logic [lfhc_pkg::HEAT_W-1:0]  heat_in,
  input  wire logic [lfhc_pkg::IDX_W-1:0]   index_in,
  input  wire logic                         last_in,
  output logic                              can_load,
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // m_tdata: pixel_index[5:0], hue[13:6], saturation[21:14], brightness[29:22]
  output logic      [31:0]                  m_tdata,
  output logic                              m_tlast
);

  logic [7:0]  hue;
  logic [7:0]  sat;
  logic [7:0]  val;
  logic [5:0]  d_hot;
  logic [11:0] x_hot;
  logic [22:0] p_hot;
  logic [7:0]  d_warm;
  logic [15:0] x_cool;
  logic [27:0] p_cool;

  // ramp terms: hot saturation ceil((t-200)*46/11), cool brightness t*255/100
  assign d_hot  = 6'(heat_in - 8'd200);
  assign x_hot  = 12'(d_hot) * 12'd46 + 12'd10;
  assign p_hot  = 23'(x_hot) * 23'd2979;
  assign d_warm = heat_in - 8'd100;
  assign x_cool = {heat_in, 8'b0} - 16'(heat_in);
  assign p_cool = 28'(x_cool) * 28'd5243;

  // pick the band of the heat value
  always_comb begin
    hue = 8'd10;
    sat = 8'd255;
    val = 8'd255;
    if (heat_in > 8'd200) begin
      hue = 8'd35;
      sat = 8'd255 - p_hot[22:15];
    end else if (heat_in > 8'd100) begin
      hue = 8'd10 + {2'b0, d_warm[7:2]};
    end else begin
      val = p_cool[26:19];
    end
  end

  assign can_load = !m_tvalid || m_tready;

  // output register with valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load && can_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      m_tdata <= {2'b0, val, sat, hue, index_in};
      m_tlast <= last_in;
    end
  end

endmodule

`default_nettype wire

[src/led_fire_heat_cells.sv]
// Fire effect heat strip: a ring of 64 heat cells plus the HSV output stage.
// Depends on lfhc_pkg, lfhc_cell and lfhc_colour.
//
// The strip is a ring of byte cells that rotates by one position per cool
// transaction, so the cell under the cool pointer always sits at the head; a
// cool transaction gives no result. A frame transaction first rotates the
// ring back to cell 0 (no rotation when the pointer is zero), then applies
// diffusion in all cells at once with the spark into one of the bottom three,
// then shifts the cells out through the colour stage at one result per cycle
// while the output is taken.
// The input accepts a new transaction only once the previous one has left the
// ring; the last colour may still sit in the output register at that point.
`default_nettype none

module led_fire_heat_cells (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // s_tdata: cooldown_amount[7:0], spark_roll[15:8], spark_cell[17:16],
  //          spark_heat[25:18]
  input  wire logic [31:0] s_tdata,
  // s_tuser: action[0]
  input  wire logic        s_tuser,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // m_tdata: pixel_index[5:0], hue[13:6], saturation[21:14], brightness[29:22]
  output logic      [31:0] m_tdata,
  // m_tlast: last_pixel
  output logic             m_tlast
);

  localparam int N = lfhc_pkg::NUM_CELLS;
  localparam int W = lfhc_pkg::HEAT_W;
  localparam int IW = lfhc_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_ALIGN   = 2'd1;
  localparam logic [1:0] ST_DIFFUSE = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  // cooldown limit (cooling*10)/12 + 1 = (cooling*5)/6 + 1
  function automatic logic [7:0] cool_limit(input logic [7:0] c);
    logic [10:0] x;
    logic [23:0] p;
    x = 11'(c) * 11'd5;
    p = 24'(x) * 24'd1366;
    return p[20:13] + 8'd1;
  endfunction

  logic [1:0]               state;
  logic [1:0]               state_next;
  logic [7:0]               limit;
  logic [7:0]               spark_chance;
  logic [IW-1:0]            ptr;
  logic [IW-1:0]            cnt;
  logic                     spark_hit;
  logic [1:0]               spark_sel;
  logic [W-1:0]             spark_heat;
  logic [W-1:0]             slot [N];
  logic [W-1:0]             ring_in;
  logic [W-1:0]             cool_amt;
  logic [W-1:0]             cooled;
  lfhc_pkg::cell_op_t       op;
  logic                     in_take;
  logic                     can_load;
  logic                     emit_go;

  logic [7:0] in_amount;
  logic [7:0] in_roll;
  logic [1:0] in_cell;
  logic [7:0] in_heat;

  assign in_amount = s_tdata[7:0];
  assign in_roll   = s_tdata[15:8];
  assign in_cell   = s_tdata[17:16];
  assign in_heat   = s_tdata[25:18];

  assign s_tready = (state == ST_IDLE);
  assign in_take  = s_tvalid && s_tready;
  assign emit_go  = (state == ST_EMIT) && can_load;

  // saturated cooldown applied to the head cell
  assign cool_amt = (in_amount < limit) ? in_amount : limit;
  assign cooled   = (cool_amt > slot[0]) ? '0 : slot[0] - cool_amt;
  assign ring_in  = (state == ST_IDLE) ? cooled : slot[0];

  // operation broadcast to all cells
  always_comb begin
    op = lfhc_pkg::OP_HOLD;
    case (state)
      ST_IDLE:    if (in_take && !s_tuser) op = lfhc_pkg::OP_SHIFT;
      ST_ALIGN:   op = lfhc_pkg::OP_SHIFT;
      ST_DIFFUSE: op = lfhc_pkg::OP_DIFFUSE;
      ST_EMIT:    if (can_load) op = lfhc_pkg::OP_SHIFT;
      default:    op = lfhc_pkg::OP_HOLD;
    endcase
  end

  // ring of cells, each shifting toward the head
  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [W-1:0] sh_in;
    logic [W-1:0] b1;
    logic [W-1:0] b2;
    logic [W-1:0] sp;

    if (j == N - 1) begin : g_top
      assign sh_in = ring_in;
    end else begin : g_mid
      assign sh_in = slot[j + 1];
    end

    if (j >= 2) begin : g_diff
      assign b1 = slot[j - 1];
      assign b2 = slot[j - 2];
    end else begin : g_keep
      // (h + 2h) / 3 keeps the two bottom cells as they are
      assign b1 = slot[j];
      assign b2 = slot[j];
    end

    if (j < 3) begin : g_spark
      assign sp = (spark_hit && spark_sel == 2'(j)) ? spark_heat : '0;
    end else begin : g_nospark
      assign sp = '0;
    end

    lfhc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .shift_in  (sh_in),
      .below1    (b1),
      .below2    (b2),
      .spark_add (sp),
      .heat      (slot[j])
    );
  end

  // colour output stage
  lfhc_colour u_colour (
    .clk      (clk),
    .rst      (rst),
    .load     (state == ST_EMIT),
    .heat_in  (slot[0]),
    .index_in (cnt),
    .last_in  (cnt == LAST_IDX),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take && s_tuser) begin
          state_next = (ptr == '0) ? ST_DIFFUSE : ST_ALIGN;
        end
      end
      ST_ALIGN: begin
        if (ptr == LAST_IDX) state_next = ST_DIFFUSE;
      end
      ST_DIFFUSE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (can_load && cnt == LAST_IDX) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cool pointer follows the ring rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else if ((state == ST_IDLE && in_take && !s_tuser) || state == ST_ALIGN) begin
      ptr <= (ptr == LAST_IDX) ? '0 : ptr + 1'b1;
    end
  end

  // emission counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == ST_DIFFUSE) begin
      cnt <= '0;
    end else if (emit_go) begin
      cnt <= cnt + 1'b1;
    end
  end

  // spark decision captured with the frame transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      spark_hit <= 1'b0;
    end else if (in_take && s_tuser) begin
      spark_hit <= (in_roll < spark_chance) && (in_cell != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && s_tuser) begin
      spark_sel  <= in_cell;
      spark_heat <= in_heat;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limit        <= cool_limit(lfhc_pkg::COOLING_RST);
      spark_chance <= lfhc_pkg::SPARK_CHANCE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lfhc_pkg::REG_COOLING:      limit <= cool_limit(cfg_data);
        lfhc_pkg::REG_SPARK_CHANCE: spark_chance <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[sim/led_fire_heat_cells_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the fire heat-cell strip led_fire_heat_cells.
// Depends on lfhc_pkg and the led_fire_heat_cells RTL; a scoreboard class
// predicts every colour transaction from the accepted input transactions.

module led_fire_heat_cells_tb;
  import lfhc_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int SETTLE_CYCLES   = 150;
  localparam int ITEMS_PER_PHASE = 74;
  localparam int PHASES          = 6;
  localparam int LONG_HOLD       = 400;
  localparam int MAX_REPORTS     = 30;

  // one colour transaction, fields as carried on m_tdata and m_tlast
  typedef struct packed {
    logic [IDX_W-1:0] pixel;
    logic [7:0]       hue;
    logic [7:0]       sat;
    logic [7:0]       bright;
    logic             last;
  } colour_t;

  // strip predictor plus queue of colours still owed by the block
  class heat_strip_scoreboard;
    logic [HEAT_W-1:0] heat [NUM_CELLS];
    logic [IDX_W-1:0]  cool_ptr;
    logic [7:0]        cooling;
    logic [7:0]        spark_chance;
    colour_t           colours_due [$];
    int errors, items, frames, cools, sparks, wraps, hot_seen, checked;

    function new();
      foreach (heat[k]) heat[k] = '0;
      cool_ptr     = '0;
      cooling      = COOLING_RST;
      spark_chance = SPARK_CHANCE_RST;
      errors = 0; items = 0; frames = 0; cools = 0;
      sparks = 0; wraps = 0; hot_seen = 0; checked = 0;
    endfunction

    function void write_reg(logic idx, logic [7:0] value);
      if (idx == REG_COOLING) cooling = value;
      else spark_chance = value;
    endfunction

    // hsv colour of one cell, integer floors of the float ramps, but a ceiling for the hot saturation step
    function colour_t flame_colour(int unsigned k, int unsigned t);
      colour_t c;
      c.pixel  = IDX_W'(k);
      c.hue    = 8'd10;
      c.sat    = 8'd255;
      c.bright = 8'd255;
      if (t > 200) begin
        c.hue = 8'd35;
        c.sat = 8'(255 - (((t - 200) * 230 + 54) / 55));
      end else if (t > 100) begin
        c.hue = 8'(10 + ((t - 100) * 25) / 100);
      end else begin
        c.bright = 8'((t * 255) / 100);
      end
      c.last = (k == NUM_CELLS - 1);
      return c;
    endfunction

    // apply one accepted input transaction to the strip
    function void absorb_item(logic action, logic [31:0] word);
      int unsigned amount, roll, tgt, limit, cut, s;
      logic [7:0] add;
      int k;
      items++;
      amount = word[7:0];
      roll   = word[15:8];
      tgt    = word[17:16];
      add    = word[25:18];
      if (action == 1'b0) begin
        cools++;
        limit = (int'(cooling) * 10) / 12 + 1;
        cut   = (amount < limit) ? amount : limit;
        if (cut > heat[cool_ptr]) heat[cool_ptr] = '0;
        else heat[cool_ptr] = HEAT_W'(heat[cool_ptr] - cut);
        if (cool_ptr == IDX_W'(NUM_CELLS - 1)) begin
          cool_ptr = '0;
          wraps++;
        end else begin
          cool_ptr = cool_ptr + 1'b1;
        end
        return;
      end
      frames++;
      // diffusion runs from the top so each cell still sees old neighbors
      for (k = NUM_CELLS - 1; k >= 2; k--) begin
        s = int'(heat[k-1]) + 2 * int'(heat[k-2]);
        heat[k] = HEAT_W'(s / 3);
      end
      // spark wraps like a byte; spark cell three adds nothing
      if (roll < spark_chance && tgt < 3) begin
        heat[tgt] = heat[tgt] + add;
        sparks++;
      end
      cool_ptr = '0;
      for (k = 0; k < NUM_CELLS; k++) begin
        if (heat[k] > 200) hot_seen++;
        colours_due.push_back(flame_colour(k, heat[k]));
      end
    endfunction

    function void report_field(string name, int want, int got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endfunction

    // compare one accepted colour transaction with the oldest expectation
    function void match_colour(logic [31:0] word, logic last);
      colour_t want, got;
      got.pixel  = word[5:0];
      got.hue    = word[13:6];
      got.sat    = word[21:14];
      got.bright = word[29:22];
      got.last   = last;
      checked++;
      if (colours_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected colour transaction, expected none actual pixel %0d",
                   $time, got.pixel);
        return;
      end
      want = colours_due.pop_front();
      if (got.pixel !== want.pixel)   report_field("pixel_index", want.pixel, got.pixel);
      if (got.hue !== want.hue)       report_field("hue", want.hue, got.hue);
      if (got.sat !== want.sat)       report_field("saturation", want.sat, got.sat);
      if (got.bright !== want.bright) report_field("brightness", want.bright, got.bright);
      if (got.last !== want.last)     report_field("last_pixel", want.last, got.last);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;  // cooldown, roll[15:8], spark cell[17:16], heat[25:18]
  logic        s_tuser   = 1'b0; // action
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;          // pixel, hue[13:6], saturation[21:14], brightness[29:22]
  logic        m_tlast;          // last pixel

  heat_strip_scoreboard sb = new();

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int holds      = 0;

  led_fire_heat_cells dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // run limit
  initial begin
    #50_000_000;
    $display("led_fire_heat_cells_tb: done, errors");
    $finish;
  end

  // receiver: check colours, stall at random, long hold-off on request
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.match_colour(m_tdata, m_tlast);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = LONG_HOLD - 1;
      holds++;
      m_tready <= 1'b0;
    end else if (steady || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                : $urandom_range(10, 40);
      m_tready <= 1'b0;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // offer one input transaction and wait until it is taken
  task automatic send_item(logic action, logic [7:0] amount, logic [7:0] roll,
                           logic [1:0] tgt, logic [7:0] add);
    logic [31:0] word;
    int gap;
    word = {6'b0, add, tgt, roll, amount};
    s_tvalid <= 1'b1;
    s_tuser  <= action;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.absorb_item(action, word);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering, wait for every owed colour, then let the ring settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.colours_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(logic [7:0] cool_val, logic [7:0] chance_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_COOLING;
    cfg_data  <= cool_val;
    @(posedge clk);
    sb.write_reg(REG_COOLING, cool_val);
    cfg_index <= REG_SPARK_CHANCE;
    cfg_data  <= chance_val;
    @(posedge clk);
    sb.write_reg(REG_SPARK_CHANCE, chance_val);
    cfg_we <= 1'b0;
  endtask

  // a run of cool transactions closed by a frame, now and then a stray one
  task automatic random_frame_run();
    int r, n;
    logic [1:0] tgt;
    logic [7:0] add;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                8'($urandom_range(0, 255)));
      return;
    end
    if (r < 16) n = $urandom_range(60, 80);
    else if (r < 28) n = 0;
    else n = $urandom_range(1, 12);
    repeat (n)
      send_item(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 99) < 85) tgt = 2'($urandom_range(0, 2));
    else tgt = 2'd3;
    if ($urandom_range(0, 99) < 75) add = 8'($urandom_range(160, 254));
    else add = 8'($urandom_range(0, 255));
    send_item(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), tgt, add);
  endtask

  // stimulus
  initial begin
    int ph, target;
    logic [7:0] cool_val, chance_val;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset config, cooldown limit 46, spark chance 55
    send_item(1'b1, 8'd0, 8'd255, 2'd0, 8'd255);   // empty strip, no spark
    send_item(1'b1, 8'd0, 8'd0, 2'd0, 8'd255);     // full spark into cell 0
    send_item(1'b1, 8'd0, 8'd54, 2'd1, 8'd160);    // roll just below chance
    send_item(1'b1, 8'd0, 8'd55, 2'd2, 8'd254);    // roll equal to chance
    send_item(1'b1, 8'd0, 8'd0, 2'd3, 8'd255);     // spark cell three
    send_item(1'b1, 8'd0, 8'd0, 2'd0, 8'd200);     // spark wraps past 255
    send_item(1'b0, 8'd0, 8'd0, 2'd0, 8'd0);
    send_item(1'b0, 8'd255, 8'd255, 2'd3, 8'd255);
    send_item(1'b0, 8'd45, 8'd0, 2'd0, 8'd0);
    send_item(1'b0, 8'd46, 8'd0, 2'd0, 8'd0);
    send_item(1'b0, 8'd47, 8'd0, 2'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 2'd2, 8'd254);
    send_item(1'b1, 8'd0, 8'd10, 2'd1, 8'd255);
    repeat (3) send_item(1'b0, 8'd128, 8'd0, 2'd0, 8'd0);
    send_item(1'b1, 8'd0, 8'd0, 2'd0, 8'd170);     // frame with pointer not at 0

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        case (ph)
          1: begin cool_val = 8'd0;   chance_val = 8'd255; end
          2: begin cool_val = 8'd255; chance_val = 8'd255; end
          3: begin cool_val = 8'd255; chance_val = 8'd0;   end
          4: begin
            cool_val   = 8'($urandom_range(0, 255));
            chance_val = 8'($urandom_range(0, 255));
          end
          default: begin cool_val = 8'd20; chance_val = 8'd200; end
        endcase
        write_regs(cool_val, chance_val);
      end
      steady = (ph == 3);
      // long output hold-off while input keeps coming
      if (ph == 2) hold_req = 1'b1;
      target = sb.items + ITEMS_PER_PHASE;
      while (sb.items < target) random_frame_run();
    end
    drain();

    $display("covered %0d inputs (%0d cool, %0d frame), %0d sparks, %0d pointer wraps",
             sb.items, sb.cools, sb.frames, sb.sparks, sb.wraps);
    $display("checked %0d colours, %0d hot cells, %0d long hold-offs, %0d errors",
             sb.checked, sb.hot_seen, holds, sb.errors);
    if (sb.errors == 0 && sb.colours_due.size() == 0) begin
      $display("led_fire_heat_cells_tb: done, clean");
    end else begin
      $display("led_fire_heat_cells_tb: done, errors");
    end
    $finish;
  end

endmodule

[files.f]
src/lfhc_pkg.sv
src/lfhc_cell.sv
src/lfhc_colour.sv
src/led_fire_heat_cells.sv
sim/led_fire_heat_cells_tb.sv
